// ===== sv/brm_pkg.sv =====
// Package: shared types and constants of the button report to MIDI encoder.
package brm_pkg;

    typedef struct packed {
        logic [17:0]        buttons;
        logic signed [15:0] bar_sample;
        logic               bar_present;
        logic [31:0]        time_us;
    } t_in_item;

    typedef struct packed {
        logic [7:0] status_byte;
        logic [7:0] data_first;
        logic [6:0] data_second;
        logic       last_of_run;
    } t_out_item;

    // Classified report handed from the front part to the back part.
    typedef struct packed {
        logic [17:0] value;
        logic [17:0] delta;
        logic        bar_changed;
        logic [13:0] bend;
        logic [31:0] dt;
    } t_job;

    localparam logic [17:0] B_GREEN  = 18'h00002;
    localparam logic [17:0] B_RED    = 18'h00004;
    localparam logic [17:0] B_BLUE   = 18'h00008;
    localparam logic [17:0] B_YELLOW = 18'h00010;
    localparam logic [17:0] B_ORANGE = 18'h00020;
    localparam logic [17:0] B_MODE   = 18'h00800;
    localparam logic [17:0] B_UPDOWN = 18'h30000;

    localparam logic [7:0] ST_NOTE = 8'h90;
    localparam logic [7:0] ST_CTRL = 8'hB0;
    localparam logic [7:0] ST_BEND = 8'hE0;
    localparam logic [7:0] CC_SUSTAIN = 8'h40;
    localparam logic [6:0] VEL_ON = 7'd127;
    localparam int HELD_NOTES = 24;
    localparam logic [4:0] OCTAVE = 5'd12;

    localparam logic [1:0] REG_BASE   = 2'd0;
    localparam logic [1:0] REG_CMD    = 2'd1;
    localparam logic [1:0] REG_WINDOW = 2'd2;

    function automatic logic [3:0] offset_of(input logic [3:0] y);
        logic [3:0] r;
        case (y)
            4'd0: r = 4'd2;
            4'd1: r = 4'd5;
            4'd2: r = 4'd7;
            4'd3: r = 4'd9;
            4'd4: r = 4'd11;
            4'd5: r = 4'd6;
            4'd6: r = 4'd8;
            4'd7: r = 4'd10;
            4'd8: r = 4'd8;
            4'd9: r = 4'd6;
            4'd10: r = 4'd11;
            4'd11: r = 4'd9;
            4'd12: r = 4'd7;
            default: r = 4'd0;
        endcase
        return r;
    endfunction

endpackage

// ===== sv/button_report_to_midi_encoder_unit.sv =====
// Top level: button report to MIDI encoder with APB configuration port.
//   channel | direction | handshake        | payload
//   report  | in        | i_valid/o_stall  | brm_pkg::t_in_item
//   message | out       | o_valid/i_stall  | brm_pkg::t_out_item
//   config  | APB       | psel/penable     | 32-bit registers at 0x0, 0x4, 0x8
// The front stage registers a report; the back part then steps through its bend, sustain,
// yellow and red/green tail states. The transpose-mode up/down note, the transpose-mode blue
// note and the second sustain message each add a state; a strum press adds the bit-serial
// window/interval divider and a strum step per string, a release the held-note scan. The front
// stage takes the next report meanwhile.
// Reset is synchronous; output stalls hold the back part's message-emitting states in place.
module button_report_to_midi_encoder_unit #(
    parameter int STRING_COUNT = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  brm_pkg::t_in_item  i_data,
    output logic               o_valid,
    input  logic               i_stall,
    output brm_pkg::t_out_item o_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    logic [6:0]  r_base, r_cmd;
    logic [21:0] r_win;
    logic        job_valid, job_stall;
    brm_pkg::t_job job;
    logic [1:0]  ridx;

    assign pready = 1'b1;
    assign ridx = paddr[3:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 7'd72;
            r_cmd <= 7'd36;
            r_win <= 22'd500000;
        end else if (psel && penable && pwrite) begin
            case (ridx)
                brm_pkg::REG_BASE:   r_base <= pwdata[6:0];
                brm_pkg::REG_CMD:    r_cmd <= pwdata[6:0];
                brm_pkg::REG_WINDOW: r_win <= pwdata[21:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (ridx)
            brm_pkg::REG_BASE:   prdata = {25'd0, r_base};
            brm_pkg::REG_CMD:    prdata = {25'd0, r_cmd};
            brm_pkg::REG_WINDOW: prdata = {10'd0, r_win};
            default:             prdata = '0;
        endcase
    end

    brm_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_job_valid(job_valid), .i_job_stall(job_stall), .o_job(job)
    );

    brm_back #(.STRING_COUNT(STRING_COUNT)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_job_valid(job_valid), .o_job_stall(job_stall), .i_job(job),
        .i_base_note(r_base), .i_command_note(r_cmd), .i_window(r_win),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data)
    );
endmodule

// ===== sv/brm_front.sv =====
// Front part: accepts reports, computes edges, bend value and strum interval.
module brm_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  brm_pkg::t_in_item i_data,
    output logic              o_job_valid,
    input  logic              i_job_stall,
    output brm_pkg::t_job     o_job
);
    logic [17:0] r_prev_buttons, n_prev_buttons;
    logic [15:0] r_prev_bar, n_prev_bar;
    logic [31:0] r_last_time, n_last_time;
    logic        r_chord, n_chord;
    logic        r_valid, n_valid;
    brm_pkg::t_job r_job, n_job;
    logic [15:0] bar;
    logic [13:0] b;
    logic        accept;

    assign o_stall = r_valid && i_job_stall;
    assign accept = i_valid && !o_stall;
    assign bar = i_data.bar_present ? i_data.bar_sample : 16'h8000;
    assign b = {1'b0, 13'(({~bar[15], bar[14:0]}) >> 3)} + 14'd8192;

    always_comb begin
        n_prev_buttons = r_prev_buttons;
        n_prev_bar = r_prev_bar;
        n_last_time = r_last_time;
        n_chord = r_chord;
        n_job = r_job;
        n_valid = r_valid && i_job_stall;
        if (accept) begin
            n_valid = 1'b1;
            n_job.value = i_data.buttons;
            n_job.delta = i_data.buttons ^ r_prev_buttons;
            n_job.bar_changed = bar != r_prev_bar;
            n_job.bend = b;
            n_job.dt = i_data.time_us - r_last_time;
            n_prev_buttons = i_data.buttons;
            n_prev_bar = bar;
            // Track the mode toggle so only chord-mode strum presses stamp the time.
            if ((n_job.delta & i_data.buttons & brm_pkg::B_MODE) != '0)
                n_chord = !r_chord;
            if (n_chord && ((n_job.delta & brm_pkg::B_UPDOWN) != '0) &&
                ((i_data.buttons & brm_pkg::B_UPDOWN) != '0))
                n_last_time = i_data.time_us;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_buttons <= '0;
            r_prev_bar <= '0;
            r_last_time <= '0;
            r_chord <= 1'b0;
            r_valid <= 1'b0;
        end else begin
            r_prev_buttons <= n_prev_buttons;
            r_prev_bar <= n_prev_bar;
            r_last_time <= n_last_time;
            r_chord <= n_chord;
            r_valid <= n_valid;
        end
        r_job <= n_job;
    end

    assign o_job_valid = r_valid;
    assign o_job = r_job;
endmodule

// ===== sv/brm_back.sv =====
// Back part: sequences the MIDI messages of one classified report.
module brm_back #(
    parameter int STRING_COUNT = 13
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_job_valid,
    output logic               o_job_stall,
    input  brm_pkg::t_job      i_job,
    input  logic [6:0]         i_base_note,
    input  logic [6:0]         i_command_note,
    input  logic [21:0]        i_window,
    output logic               o_valid,
    input  logic               i_stall,
    output brm_pkg::t_out_item o_data
);
    typedef enum logic [9:0] {
        S_IDLE  = 10'b0000000001,
        S_BEND  = 10'b0000000010,
        S_DIV   = 10'b0000000100,
        S_UD    = 10'b0000001000,
        S_STRUM = 10'b0000010000,
        S_REL   = 10'b0000100000,
        S_SUS   = 10'b0001000000,
        S_YEL   = 10'b0010000000,
        S_YEL2  = 10'b0100000000,
        S_TAIL  = 10'b1000000000
    } t_state;

    localparam logic [3:0] SC = 4'(STRING_COUNT);

    t_state r_state, n_state;
    brm_pkg::t_job r_job, n_job;
    logic        r_chord, n_chord;
    logic [3:0]  r_pos, n_pos;
    logic        r_oct, n_oct;
    logic        r_first, n_first;
    logic [brm_pkg::HELD_NOTES-1:0] r_held, n_held;
    logic        r_sus, n_sus;
    logic [4:0]  r_idx, n_idx;
    logic [2:0]  r_tail, n_tail;
    logic [3:0]  r_n, n_n;
    logic [3:0]  r_x, n_x;
    // Restoring divider: window / dt, quotient saturates at STRING_COUNT.
    logic [21:0] r_rem, n_rem;
    logic [21:0] r_q, n_q;
    logic [21:0] r_dq, n_dq;
    logic [4:0]  r_dcnt, n_dcnt;
    brm_pkg::t_out_item r_out, n_out;
    logic        r_ovalid, n_ovalid;
    logic [23:0] r_pend, n_pend;
    logic        r_pv, n_pv;
    logic        flush;

    logic        emit;
    brm_pkg::t_out_item msg;
    logic        slot_free;
    logic [17:0] v, d;
    logic [3:0]  p, y;
    logic [4:0]  note;
    logic [22:0] trial;
    logic        is_blue, is_or;

    function automatic logic [3:0] nxt(input logic [3:0] q);
        logic [3:0] t;
        t = q + 4'd1;
        return (t >= SC) ? 4'd0 : t;
    endfunction

    function automatic logic [3:0] prv(input logic [3:0] q);
        return (q == 4'd0) ? SC - 4'd1 : q - 4'd1;
    endfunction

    assign v = r_job.value;
    assign d = r_job.delta;
    assign is_blue = (v & brm_pkg::B_BLUE) != '0;
    assign is_or = (v & brm_pkg::B_ORANGE) != '0;
    assign slot_free = !r_ovalid || !i_stall;
    assign o_job_stall = r_state != S_IDLE;
    assign trial = {r_rem, r_dq[21]} - {1'b0, r_job.dt[21:0]};

    always_comb begin
        n_state = r_state;
        n_job = r_job;
        n_chord = r_chord;
        n_pos = r_pos;
        n_oct = r_oct;
        n_first = r_first;
        n_held = r_held;
        n_sus = r_sus;
        n_idx = r_idx;
        n_tail = r_tail;
        n_n = r_n;
        n_x = r_x;
        n_rem = r_rem;
        n_q = r_q;
        n_dq = r_dq;
        n_dcnt = r_dcnt;
        emit = 1'b0;
        msg = '0;
        p = r_pos;
        y = '0;
        note = '0;
        case (r_state)
            S_IDLE: begin
                if (i_job_valid) begin
                    n_job = i_job;
                    if ((i_job.delta & i_job.value & brm_pkg::B_MODE) != '0)
                        n_chord = !r_chord;
                    n_state = S_BEND;
                end
            end
            S_BEND: begin
                if (slot_free) begin
                    if (r_job.bar_changed) begin
                        emit = 1'b1;
                        msg.status_byte = brm_pkg::ST_BEND;
                        msg.data_first = {1'b0, r_job.bend[6:0]};
                        msg.data_second = r_job.bend[13:7];
                    end
                    n_state = S_UD;
                    if ((d & brm_pkg::B_UPDOWN) == '0)
                        n_state = S_SUS;
                    else if (r_chord && (v & brm_pkg::B_UPDOWN) != '0) begin
                        n_rem = '0;
                        n_dq = i_window;
                        n_q = '0;
                        n_dcnt = 5'd22;
                        n_x = '0;
                        n_state = S_DIV;
                    end else if (r_chord) begin
                        n_idx = '0;
                        n_state = S_REL;
                    end
                end
            end
            S_UD: begin
                if (slot_free) begin
                    emit = 1'b1;
                    msg.status_byte = brm_pkg::ST_NOTE;
                    msg.data_first = {1'b0, i_base_note};
                    msg.data_second = ((v & brm_pkg::B_UPDOWN) != '0) ?
                        brm_pkg::VEL_ON : 7'd0;
                    n_state = S_SUS;
                end
            end
            S_DIV: begin
                if (r_dcnt != '0) begin
                    if (!trial[22]) begin
                        n_rem = trial[21:0];
                        n_q = {r_q[20:0], 1'b1};
                    end else begin
                        n_rem = {r_rem[20:0], r_dq[21]};
                        n_q = {r_q[20:0], 1'b0};
                    end
                    n_dq = {r_dq[20:0], 1'b0};
                    n_dcnt = r_dcnt - 5'd1;
                end else begin
                    if (r_job.dt >= {10'd0, i_window})
                        n_n = 4'd1;
                    else if (r_job.dt == '0 || r_q >= 22'(STRING_COUNT))
                        n_n = SC;
                    else
                        n_n = r_q[3:0];
                    n_state = S_STRUM;
                end
            end
            S_STRUM: begin
                if (slot_free) begin
                    if (is_blue && is_or) begin
                        y = r_pos;
                    end else if (r_first) begin
                        if (r_pos == 4'd0) begin
                            if (is_blue) p = nxt(p);
                            if (is_or) p = prv(p);
                        end
                        n_first = 1'b0;
                        y = '0;
                    end else if (is_blue) begin
                        p = nxt(r_pos);
                        if (p == 4'd0 && r_n > 4'd1) p = nxt(p);
                        y = p;
                    end else if (is_or) begin
                        p = prv(r_pos);
                        if (p == 4'd0 && r_n > 4'd1) p = prv(p);
                        y = p;
                    end else begin
                        y = r_pos;
                    end
                    n_pos = p;
                    note = (r_oct ? brm_pkg::OCTAVE : 5'd0) + {1'b0, brm_pkg::offset_of(y)};
                    if (note < 5'(brm_pkg::HELD_NOTES) && !r_held[note]) begin
                        n_held[note] = 1'b1;
                        emit = 1'b1;
                        msg.status_byte = brm_pkg::ST_NOTE;
                        msg.data_first = {1'b0, i_base_note} + {3'd0, note};
                        msg.data_second = brm_pkg::VEL_ON;
                    end
                    n_x = r_x + 4'd1;
                    if (n_x == r_n) n_state = S_SUS;
                end
            end
            S_REL: begin
                if (slot_free) begin
                    if (r_held[r_idx]) begin
                        n_held[r_idx] = 1'b0;
                        emit = 1'b1;
                        msg.status_byte = brm_pkg::ST_NOTE;
                        msg.data_first = {1'b0, i_base_note} + {3'd0, r_idx};
                        msg.data_second = '0;
                    end
                    n_idx = r_idx + 5'd1;
                    if (r_idx == 5'(brm_pkg::HELD_NOTES - 1)) n_state = S_SUS;
                end
            end
            S_SUS: begin
                if (slot_free) begin
                    if ((d & (brm_pkg::B_ORANGE | brm_pkg::B_BLUE)) != '0 && r_chord) begin
                        emit = 1'b1;
                        n_sus = (v & (brm_pkg::B_ORANGE | brm_pkg::B_BLUE)) != '0;
                    end else if ((d & brm_pkg::B_ORANGE) != '0 && !r_chord) begin
                        emit = 1'b1;
                        n_sus = is_or;
                    end
                    msg.status_byte = brm_pkg::ST_CTRL;
                    msg.data_first = brm_pkg::CC_SUSTAIN;
                    msg.data_second = n_sus ? brm_pkg::VEL_ON : 7'd0;
                    n_tail = 3'd0;
                    n_state = S_YEL;
                end
            end
            S_YEL: begin
                if (slot_free) begin
                    n_state = S_TAIL;
                    if ((d & brm_pkg::B_YELLOW) != '0) begin
                        if (!r_chord) begin
                            emit = 1'b1;
                            msg.status_byte = brm_pkg::ST_NOTE;
                            msg.data_first = {1'b0, i_command_note} + 8'd2;
                            msg.data_second = ((v & brm_pkg::B_YELLOW) != '0) ?
                                brm_pkg::VEL_ON : 7'd0;
                        end else if ((v & brm_pkg::B_YELLOW) != '0) begin
                            n_oct = !r_oct;
                            n_first = 1'b1;
                            if (is_blue && is_or) n_pos = 4'd0;
                            else if (is_blue) n_pos = 4'd7;
                            else if (is_or) n_pos = 4'd1;
                            else n_pos = 4'd0;
                            if (r_sus) begin
                                emit = 1'b1;
                                msg.status_byte = brm_pkg::ST_CTRL;
                                msg.data_first = brm_pkg::CC_SUSTAIN;
                                msg.data_second = '0;
                                n_state = S_YEL2;
                            end
                        end
                    end
                    // Blue command note in transpose mode precedes yellow.
                    if ((d & brm_pkg::B_BLUE) != '0 && !r_chord) begin
                        emit = 1'b1;
                        msg.status_byte = brm_pkg::ST_NOTE;
                        msg.data_first = {1'b0, i_command_note} + 8'd3;
                        msg.data_second = is_blue ? brm_pkg::VEL_ON : 7'd0;
                        n_job.delta = d & ~brm_pkg::B_BLUE;
                        n_oct = r_oct;
                        n_first = r_first;
                        n_pos = r_pos;
                        n_state = S_YEL;
                    end
                end
            end
            S_YEL2: begin
                if (slot_free) begin
                    emit = 1'b1;
                    msg.status_byte = brm_pkg::ST_CTRL;
                    msg.data_first = brm_pkg::CC_SUSTAIN;
                    msg.data_second = brm_pkg::VEL_ON;
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                if (slot_free) begin
                    if (r_tail == 3'd0) begin
                        if ((d & brm_pkg::B_RED) != '0) begin
                            emit = 1'b1;
                            msg.status_byte = brm_pkg::ST_NOTE;
                            msg.data_first = {1'b0, i_command_note} + 8'd1;
                            msg.data_second = ((v & brm_pkg::B_RED) != '0) ?
                                brm_pkg::VEL_ON : 7'd0;
                        end
                        n_tail = 3'd1;
                    end else if (r_tail == 3'd1) begin
                        if ((d & brm_pkg::B_GREEN) != '0) begin
                            emit = 1'b1;
                            msg.status_byte = brm_pkg::ST_NOTE;
                            msg.data_first = {1'b0, i_command_note};
                            msg.data_second = ((v & brm_pkg::B_GREEN) != '0) ?
                                brm_pkg::VEL_ON : 7'd0;
                        end
                        n_tail = 3'd2;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign flush = (r_state == S_TAIL) && (r_tail == 3'd2) && slot_free;

    // One-entry hold: a message is released once the next one (or the end) is known,
    // so its last flag can be set.
    always_comb begin
        n_out = r_out;
        n_ovalid = r_ovalid && i_stall;
        n_pend = r_pend;
        n_pv = r_pv;
        if (slot_free) begin
            if (r_pv && (emit || flush)) begin
                n_out = brm_pkg::t_out_item'(r_pend);
                n_out.last_of_run = flush && !emit;
                n_ovalid = 1'b1;
            end
            if (emit) begin
                n_pend = {msg.status_byte, msg.data_first, msg.data_second, 1'b0};
                n_pv = 1'b1;
            end else if (flush) begin
                n_pv = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_chord <= 1'b0;
            r_pos <= '0;
            r_oct <= 1'b0;
            r_first <= 1'b0;
            r_held <= '0;
            r_sus <= 1'b0;
            r_ovalid <= 1'b0;
            r_pv <= 1'b0;
        end else begin
            r_state <= n_state;
            r_chord <= n_chord;
            r_pos <= n_pos;
            r_oct <= n_oct;
            r_first <= n_first;
            r_held <= n_held;
            r_sus <= n_sus;
            r_ovalid <= n_ovalid;
            r_pv <= n_pv;
        end
        r_job <= n_job;
        r_idx <= n_idx;
        r_tail <= n_tail;
        r_n <= n_n;
        r_x <= n_x;
        r_rem <= n_rem;
        r_q <= n_q;
        r_dq <= n_dq;
        r_dcnt <= n_dcnt;
        r_out <= n_out;
        r_pend <= n_pend;
    end

    assign o_valid = r_ovalid;
    assign o_data = r_out;
endmodule

// ===== tb/testbench.sv =====
// Testbench for the button report to MIDI encoder: directed and random reports against a predictor.
`timescale 1ns / 1ps

module testbench;
    localparam int STRINGS = 13;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE_CYCLES = 200;
    localparam int MAX_MSGS = 30;
    localparam logic [3:0] ADDR_BASE   = 4'h0;
    localparam logic [3:0] ADDR_CMD    = 4'h4;
    localparam logic [3:0] ADDR_WINDOW = 4'h8;
    localparam logic [3:0] STRING_OFFSETS [16] = '{4'd2, 4'd5, 4'd7, 4'd9, 4'd11, 4'd6, 4'd8,
        4'd10, 4'd8, 4'd6, 4'd11, 4'd9, 4'd7, 4'd0, 4'd0, 4'd0};
    localparam logic [17:0] FRET_MASK = brm_pkg::B_GREEN | brm_pkg::B_RED | brm_pkg::B_BLUE |
        brm_pkg::B_YELLOW | brm_pkg::B_ORANGE;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    brm_pkg::t_in_item  i_data;
    logic        o_valid;
    logic        i_stall;
    brm_pkg::t_out_item o_data;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    button_report_to_midi_encoder_unit DUT (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall), .i_data(i_data),
        .o_valid(o_valid), .i_stall(i_stall), .o_data(o_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // encoder state as predicted
    logic [6:0]  cfg_base;
    logic [6:0]  cfg_cmd;
    logic [21:0] cfg_window;
    logic        pm_chord;
    logic [17:0] pm_prev_buttons;
    logic [15:0] pm_prev_bar;
    logic [3:0]  pm_pos;
    logic        pm_octave;
    logic        pm_first_pending;
    logic [23:0] pm_held;
    logic        pm_sustain;
    logic [31:0] pm_last_strum;

    brm_pkg::t_out_item expected_msgs[$];
    brm_pkg::t_out_item run_msgs[$];
    int          errors;
    int          cycles;
    int          burst_left;
    int          stall_mode;
    int          stall_count;
    logic [31:0] clock_us;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    function automatic logic [3:0] step_up(input logic [3:0] p);
        logic [3:0] r;
        r = p + 4'd1;
        if (r >= STRINGS) r = 4'd0;
        return r;
    endfunction

    function automatic logic [3:0] step_down(input logic [3:0] p);
        logic [3:0] r;
        r = (p == 4'd0) ? 4'(STRINGS) : p;
        return r - 4'd1;
    endfunction

    task automatic add_msg(input logic [7:0] st, input logic [7:0] d1, input logic [6:0] d2);
        brm_pkg::t_out_item m;
        if (run_msgs.size() < MAX_MSGS) begin
            m.status_byte = st;
            m.data_first  = d1;
            m.data_second = d2;
            m.last_of_run = 1'b0;
            run_msgs.push_back(m);
        end
    endtask

    task automatic reset_encoder_model();
        cfg_base = 7'd72;
        cfg_cmd = 7'd36;
        cfg_window = 22'd500000;
        pm_chord = 1'b0;
        pm_prev_buttons = '0;
        pm_prev_bar = '0;
        pm_pos = '0;
        pm_octave = 1'b0;
        pm_first_pending = 1'b0;
        pm_held = '0;
        pm_sustain = 1'b0;
        pm_last_strum = '0;
    endtask

    task automatic predict_midi(input brm_pkg::t_in_item r);
        logic [17:0] v;
        logic [17:0] d;
        logic [15:0] bar;
        logic [31:0] bend;
        logic [31:0] dt;
        logic [31:0] n;
        logic [4:0]  sh;
        logic [3:0]  y;
        logic [5:0]  note;
        v = r.buttons;
        bar = r.bar_present ? r.bar_sample : 16'h8000;
        run_msgs.delete();
        if (bar != pm_prev_bar) begin
            pm_prev_bar = bar;
            bend = 32'((bar ^ 16'h8000) >> 3) + 32'd8192;
            if (bend > 32'h3FFF) bend = 32'h3FFF;
            add_msg(brm_pkg::ST_BEND, {1'b0, bend[6:0]}, bend[13:7]);
        end
        d = pm_prev_buttons ^ v;
        pm_prev_buttons = v;
        if ((d & v & brm_pkg::B_MODE) != 0) pm_chord = ~pm_chord;
        sh = pm_octave ? brm_pkg::OCTAVE : 5'd0;
        if ((d & brm_pkg::B_UPDOWN) != 0) begin
            if (!pm_chord) begin
                add_msg(brm_pkg::ST_NOTE, {1'b0, cfg_base},
                        ((v & brm_pkg::B_UPDOWN) != 0) ? brm_pkg::VEL_ON : 7'd0);
            end else if ((v & brm_pkg::B_UPDOWN) != 0) begin
                dt = r.time_us - pm_last_strum;
                pm_last_strum = r.time_us;
                if (dt < cfg_window) begin
                    n = (dt == 0) ? STRINGS : cfg_window / dt;
                    if (n > STRINGS) n = STRINGS;
                end else begin
                    n = 1;
                end
                for (int x = 0; x < n; x++) begin
                    if ((v & brm_pkg::B_BLUE) != 0 && (v & brm_pkg::B_ORANGE) != 0) begin
                        y = pm_pos;
                    end else if (pm_first_pending) begin
                        if (pm_pos == 0) begin
                            if ((v & brm_pkg::B_BLUE) != 0) pm_pos = step_up(pm_pos);
                            if ((v & brm_pkg::B_ORANGE) != 0) pm_pos = step_down(pm_pos);
                        end
                        pm_first_pending = 1'b0;
                        y = 4'd0;
                    end else if ((v & brm_pkg::B_BLUE) != 0) begin
                        pm_pos = step_up(pm_pos);
                        if (pm_pos == 0 && n > 1) pm_pos = step_up(pm_pos);
                        y = pm_pos;
                    end else if ((v & brm_pkg::B_ORANGE) != 0) begin
                        pm_pos = step_down(pm_pos);
                        if (pm_pos == 0 && n > 1) pm_pos = step_down(pm_pos);
                        y = pm_pos;
                    end else begin
                        y = pm_pos;
                    end
                    note = 6'(sh) + 6'(STRING_OFFSETS[y]);
                    if (note < brm_pkg::HELD_NOTES && !pm_held[note]) begin
                        pm_held[note] = 1'b1;
                        add_msg(brm_pkg::ST_NOTE, 8'(cfg_base) + 8'(note), brm_pkg::VEL_ON);
                    end
                end
            end else begin
                for (int x = 0; x < brm_pkg::HELD_NOTES; x++) begin
                    if (pm_held[x]) begin
                        pm_held[x] = 1'b0;
                        add_msg(brm_pkg::ST_NOTE, 8'(cfg_base) + 8'(x), 7'd0);
                    end
                end
            end
        end
        if ((d & (brm_pkg::B_ORANGE | brm_pkg::B_BLUE)) != 0 && pm_chord) begin
            pm_sustain = (v & (brm_pkg::B_ORANGE | brm_pkg::B_BLUE)) != 0;
            add_msg(brm_pkg::ST_CTRL, brm_pkg::CC_SUSTAIN,
                    pm_sustain ? brm_pkg::VEL_ON : 7'd0);
        end
        if ((d & brm_pkg::B_ORANGE) != 0 && !pm_chord) begin
            pm_sustain = (v & brm_pkg::B_ORANGE) != 0;
            add_msg(brm_pkg::ST_CTRL, brm_pkg::CC_SUSTAIN,
                    pm_sustain ? brm_pkg::VEL_ON : 7'd0);
        end
        if ((d & brm_pkg::B_BLUE) != 0 && !pm_chord)
            add_msg(brm_pkg::ST_NOTE, 8'(cfg_cmd) + 8'd3,
                    ((v & brm_pkg::B_BLUE) != 0) ? brm_pkg::VEL_ON : 7'd0);
        if ((d & brm_pkg::B_YELLOW) != 0) begin
            if (!pm_chord) begin
                add_msg(brm_pkg::ST_NOTE, 8'(cfg_cmd) + 8'd2,
                        ((v & brm_pkg::B_YELLOW) != 0) ? brm_pkg::VEL_ON : 7'd0);
            end else if ((v & brm_pkg::B_YELLOW) != 0) begin
                pm_octave = ~pm_octave;
                pm_first_pending = 1'b1;
                if ((v & brm_pkg::B_BLUE) != 0 && (v & brm_pkg::B_ORANGE) != 0) pm_pos = 4'd0;
                else if ((v & brm_pkg::B_BLUE) != 0) pm_pos = 4'd7;
                else if ((v & brm_pkg::B_ORANGE) != 0) pm_pos = 4'd1;
                else pm_pos = 4'd0;
                if (pm_sustain) begin
                    add_msg(brm_pkg::ST_CTRL, brm_pkg::CC_SUSTAIN, 7'd0);
                    add_msg(brm_pkg::ST_CTRL, brm_pkg::CC_SUSTAIN, brm_pkg::VEL_ON);
                end
            end
        end
        if ((d & brm_pkg::B_RED) != 0)
            add_msg(brm_pkg::ST_NOTE, 8'(cfg_cmd) + 8'd1,
                    ((v & brm_pkg::B_RED) != 0) ? brm_pkg::VEL_ON : 7'd0);
        if ((d & brm_pkg::B_GREEN) != 0)
            add_msg(brm_pkg::ST_NOTE, {1'b0, cfg_cmd},
                    ((v & brm_pkg::B_GREEN) != 0) ? brm_pkg::VEL_ON : 7'd0);
        if (run_msgs.size() > 0) run_msgs[run_msgs.size() - 1].last_of_run = 1'b1;
        foreach (run_msgs[k]) expected_msgs.push_back(run_msgs[k]);
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("MISMATCH %s: got 0x%0h expected 0x%0h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    // check each message transaction against the oldest expectation
    always @(posedge i_clk) begin
        brm_pkg::t_out_item want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_msgs.size() == 0) begin
                report_mismatch("unexpected message", o_data, 0);
            end else begin
                want = expected_msgs.pop_front();
                if (o_data.status_byte != want.status_byte)
                    report_mismatch("status_byte", o_data.status_byte, want.status_byte);
                if (o_data.data_first != want.data_first)
                    report_mismatch("data_first", o_data.data_first, want.data_first);
                if (o_data.data_second != want.data_second)
                    report_mismatch("data_second", o_data.data_second, want.data_second);
                if (o_data.last_of_run != want.last_of_run)
                    report_mismatch("last_of_run", o_data.last_of_run, want.last_of_run);
            end
        end
    end

    // receiver stall pattern: free running, random, or long bursts
    always @(posedge i_clk) begin
        if (stall_count == 0) begin
            stall_mode <= $urandom_range(0, 3);
            stall_count <= $urandom_range(20, 300);
        end else begin
            stall_count <= stall_count - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 1) == 0);
            2: i_stall <= ((stall_count % 16) < 10);
            default: i_stall <= ($urandom_range(0, 7) == 0);
        endcase
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout at cycle %0d", cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    task automatic send_report(input logic [17:0] b, input logic [15:0] bar, input logic pres,
                               input logic [31:0] t);
        brm_pkg::t_in_item r;
        r.buttons = b;
        r.bar_sample = bar;
        r.bar_present = pres;
        r.time_us = t;
        i_valid <= 1'b1;
        i_data <= r;
        do @(posedge i_clk); while (o_stall);
        predict_midi(r);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = $urandom_range(0, 9);
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic drain_messages();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_msgs.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [3:0] addr, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (addr)
            ADDR_BASE:   cfg_base = val[6:0];
            ADDR_CMD:    cfg_cmd = val[6:0];
            default:     cfg_window = val[21:0];
        endcase
    endtask

    task automatic set_config(input logic [6:0] base, input logic [6:0] cmd,
                              input logic [21:0] win);
        drain_messages();
        write_reg(ADDR_BASE, {25'd0, base});
        write_reg(ADDR_CMD, {25'd0, cmd});
        write_reg(ADDR_WINDOW, {10'd0, win});
    endtask

    task automatic test_directed();
        // bar extremes, absent bar, an all-buttons report that toggles chord mode on, then chord-mode edges
        send_report(18'h00000, 16'h7FFF, 1'b1, 32'd100);
        send_report(18'h00000, 16'h8000, 1'b1, 32'd200);
        send_report(18'h00000, 16'h0000, 1'b0, 32'd300);
        send_report(18'h3FFFF, 16'h0000, 1'b1, 32'hFFFF_FFFF);
        send_report(18'h00000, 16'hFFFF, 1'b1, 32'd0);
        send_report(FRET_MASK | brm_pkg::B_UPDOWN, 16'hFFFF, 1'b1, 32'd10);
        send_report(18'h00000, 16'h1234, 1'b1, 32'd20);
        // toggle back out of chord mode, then up/down and fret edges at zero, short and long time steps
        send_report(brm_pkg::B_MODE, 16'h1234, 1'b1, 32'd30);
        send_report(18'h10000 | brm_pkg::B_BLUE, 16'h1234, 1'b1, 32'd30);
        send_report(18'h20000 | brm_pkg::B_BLUE, 16'h1234, 1'b1, 32'd30);
        send_report(18'h10000 | brm_pkg::B_BLUE, 16'h1234, 1'b1, 32'd50030);
        send_report(18'h20000 | brm_pkg::B_ORANGE, 16'h1234, 1'b1, 32'd100030);
        send_report(18'h10000 | brm_pkg::B_ORANGE | brm_pkg::B_BLUE, 16'h1234, 1'b1,
                    32'd900000);
        send_report(18'h00000, 16'h1234, 1'b1, 32'd900001);
        send_report(brm_pkg::B_YELLOW | brm_pkg::B_BLUE, 16'h1234, 1'b1, 32'd900002);
        send_report(18'h10000 | brm_pkg::B_BLUE, 16'h1234, 1'b1, 32'd900002);
        send_report(brm_pkg::B_ORANGE, 16'h1234, 1'b1, 32'd900003);
        send_report(brm_pkg::B_YELLOW | brm_pkg::B_ORANGE, 16'h1234, 1'b1, 32'd900004);
        send_report(18'h20000 | brm_pkg::B_ORANGE, 16'h1234, 1'b1, 32'd900004);
        send_report(brm_pkg::B_YELLOW | brm_pkg::B_ORANGE | brm_pkg::B_BLUE, 16'h1234, 1'b1,
                    32'd900005);
        send_report(18'h10000 | brm_pkg::B_ORANGE | brm_pkg::B_BLUE, 16'h1234, 1'b1,
                    32'd900005);
        // time stepping backwards, then an up/down release with red and green edges
        send_report(18'h20000, 16'h1234, 1'b1, 32'd10);
        send_report(brm_pkg::B_RED | brm_pkg::B_GREEN, 16'h0000, 1'b0, 32'd20);
        send_report(brm_pkg::B_MODE, 16'h0000, 1'b0, 32'd30);
    endtask

    task automatic send_random(input int count);
        logic [17:0] b;
        logic [15:0] bar;
        logic        pres;
        logic [17:0] frets;
        for (int k = 0; k < count; k++) begin
            case ($urandom_range(0, 9))
                0: clock_us = $urandom;
                1, 2: clock_us = clock_us;
                3, 4, 5: clock_us = clock_us + $urandom_range(1, cfg_window / 13 + 1);
                6, 7: clock_us = clock_us + $urandom_range(1, cfg_window + 1);
                default: clock_us = clock_us + $urandom_range(1, 5000000);
            endcase
            frets = 18'($urandom) & FRET_MASK;
            case ($urandom_range(0, 9))
                0: b = 18'($urandom);
                1: b = frets | (($urandom_range(0, 3) == 0) ? brm_pkg::B_MODE : 18'h0);
                2, 3, 4: b = frets | 18'h10000;
                5, 6: b = frets | 18'h20000;
                7: b = frets;
                default: b = frets | brm_pkg::B_UPDOWN;
            endcase
            if ($urandom_range(0, 2) == 0) begin
                bar = 16'($urandom);
                pres = ($urandom_range(0, 5) != 0);
            end else begin
                bar = pm_prev_bar;
                pres = 1'b1;
            end
            send_report(b, bar, pres, clock_us);
        end
    endtask

    task automatic test_random_default();
        send_report(brm_pkg::B_MODE, 16'h0, 1'b1, clock_us);
        send_random(80);
    endtask

    task automatic test_config_extremes();
        set_config(7'd0, 7'd115, 22'd1);
        send_random(25);
        set_config(7'd115, 7'd0, 22'd4000000);
        send_random(25);
        set_config(7'd127, 7'd127, 22'd0);
        send_random(15);
        set_config(7'($urandom_range(0, 115)), 7'($urandom_range(0, 115)),
                   22'($urandom_range(1, 4000000)));
        send_random(15);
        set_config(7'd72, 7'd36, 22'h3FFFFF);
        send_random(40);
    endtask

    initial begin
        errors = 0;
        cycles = 0;
        burst_left = 0;
        stall_mode = 0;
        stall_count = 0;
        clock_us = '0;
        reset_encoder_model();
        i_rst_n <= 1'b0;
        i_valid <= 1'b0;
        i_data <= '0;
        i_stall <= 1'b0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        test_directed();
        test_random_default();
        test_config_extremes();

        drain_messages();
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule

// ===== files.f =====
sv/brm_pkg.sv
sv/brm_front.sv
sv/brm_back.sv
sv/button_report_to_midi_encoder_unit.sv
tb/testbench.sv
